>>> rtl/core/rgb3_pkg.sv
// Shared types, constants and arithmetic helpers for the RGB 3x3 convolution filter.
`default_nettype none

package rgb3_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 4096;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ROW_W      = $clog2(MAX_HEIGHT);
    localparam int WID_W      = 11;
    localparam int HGT_W      = 13;
    localparam int KERN_W     = 36;
    localparam int SHIFT_W    = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int PROD_W     = 13;
    localparam int PSUM_W     = 14;
    localparam int SUM_W      = 16;

    localparam logic [KERN_W-1:0]  KERNEL_RST = 36'h121242121;
    localparam logic [SHIFT_W-1:0] SHIFT_RST  = 3'd4;
    localparam logic [WID_W-1:0]   WIDTH_RST  = 11'd640;
    localparam logic [HGT_W-1:0]   HEIGHT_RST = 13'd480;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_KERNEL = 2'd0,
        CFG_SHIFT  = 2'd1,
        CFG_WIDTH  = 2'd2,
        CFG_HEIGHT = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_pix;

    // one window column: row above-above, row above, current row
    typedef struct packed {
        t_pix top;
        t_pix mid;
        t_pix bot;
    } t_col;

    typedef struct packed {
        logic signed [PSUM_W-1:0] red;
        logic signed [PSUM_W-1:0] green;
        logic signed [PSUM_W-1:0] blue;
    } t_psum;

    typedef struct packed {
        logic [7:0] red_in;
        logic [7:0] green_in;
        logic [7:0] blue_in;
        logic       frame_start;
    } t_in_req;

    typedef struct packed {
        logic [7:0]       red_out;
        logic [7:0]       green_out;
        logic [7:0]       blue_out;
        logic [COL_W-1:0] centre_column;
        logic [ROW_W-1:0] centre_row;
    } t_out_req;

    // unsigned pixel channel times signed 4-bit coefficient
    function automatic logic signed [PROD_W-1:0] mul_px(input logic [7:0] px,
                                                        input logic [3:0] cf);
        logic signed [PROD_W-1:0] a;
        logic signed [PROD_W-1:0] b;
        a = {5'b0, px};
        b = {{(PROD_W-4){cf[3]}}, cf};
        return PROD_W'(a * b);
    endfunction

    // divide by 2^sh toward zero and clamp to 0..255
    function automatic logic [7:0] norm_ch(input logic signed [SUM_W-1:0] s,
                                           input logic [SHIFT_W-1:0]   sh);
        logic [SUM_W-2:0] q;
        q = s[SUM_W-2:0] >> sh;
        if (s[SUM_W-1]) begin
            return 8'd0;
        end else if (q > (SUM_W-1)'(255)) begin
            return 8'hFF;
        end else begin
            return q[7:0];
        end
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/rgb3_line_buf.sv
// Two line stores with registered read and same-address write forwarding.
`default_nettype none

module rgb3_line_buf
    import rgb3_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_en,
    input  wire logic [COL_W-1:0] i_rd_addr,
    input  wire logic             i_wr_en,
    input  wire logic [COL_W-1:0] i_wr_addr,
    input  wire t_pix             i_wr_px,
    output t_pix                  o_top,
    output t_pix                  o_mid
);

    t_pix mem_upper  [MAX_WIDTH];
    t_pix mem_middle [MAX_WIDTH];

    t_pix r_q_top;
    t_pix r_q_mid;
    t_pix r_byp_top;
    t_pix r_byp_mid;
    logic r_byp;

    assign o_top = r_byp ? r_byp_top : r_q_top;
    assign o_mid = r_byp ? r_byp_mid : r_q_mid;

    // the row above moves up one store as the current pixel lands in the middle one
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem_upper[i_wr_addr]  <= o_mid;
            mem_middle[i_wr_addr] <= i_wr_px;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_q_top   <= mem_upper[i_rd_addr];
            r_q_mid   <= mem_middle[i_rd_addr];
            r_byp_top <= o_mid;
            r_byp_mid <= i_wr_px;
        end
    end

    // forward a write that lands on the address read at the same edge
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byp <= 1'b0;
        end else if (i_en) begin
            r_byp <= i_wr_en && (i_wr_addr == i_rd_addr);
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/rgb3_tap_cell.sv
// Window column cell: holds one column of the 3x3 window and its weighted partial sum.
`default_nettype none

module rgb3_tap_cell
    import rgb3_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_shift,
    input  wire logic        i_en,
    input  wire t_col        i_col,
    input  wire logic [11:0] i_coefs,
    output t_col             o_col,
    output t_psum            o_psum
);

    t_col  r_col;
    t_psum r_psum;
    t_psum n_psum;

    assign o_col  = r_col;
    assign o_psum = r_psum;

    always_comb begin
        n_psum.red   = PSUM_W'(mul_px(r_col.top.red,   i_coefs[3:0]))
                     + PSUM_W'(mul_px(r_col.mid.red,   i_coefs[7:4]))
                     + PSUM_W'(mul_px(r_col.bot.red,   i_coefs[11:8]));
        n_psum.green = PSUM_W'(mul_px(r_col.top.green, i_coefs[3:0]))
                     + PSUM_W'(mul_px(r_col.mid.green, i_coefs[7:4]))
                     + PSUM_W'(mul_px(r_col.bot.green, i_coefs[11:8]));
        n_psum.blue  = PSUM_W'(mul_px(r_col.top.blue,  i_coefs[3:0]))
                     + PSUM_W'(mul_px(r_col.mid.blue,  i_coefs[7:4]))
                     + PSUM_W'(mul_px(r_col.bot.blue,  i_coefs[11:8]));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
        end else if (i_shift) begin
            r_col <= i_col;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_psum <= n_psum;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/rgb_3x3_convolution_filter.sv
// Top level of the streaming RGB 3x3 convolution filter.
// After its pixel request is taken, a result passes the stage-2, window-cell, partial-sum and output registers.
// Throughput: one pixel per cycle; the input stalls only while a result waits and
// the output side stalls, since the whole pipeline advances together.
// Reset: kernel 1 2 1 / 2 4 2 / 1 2 1, shift 4, 640 x 480, counters and window cleared;
// line store contents stay undefined until written.
`default_nettype none

module rgb_3x3_convolution_filter
    import rgb3_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_stall,
    input  wire t_in_req              i_in_req,
    output logic                      o_out_valid,
    input  wire logic                 i_out_stall,
    output t_out_req                  o_out_req,
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [KERN_W-1:0]    i_cfg_data
);

    logic [KERN_W-1:0]  r_kernel;
    logic [SHIFT_W-1:0] r_shift;
    logic [WID_W-1:0]   r_width;
    logic [HGT_W-1:0]   r_height;

    logic [COL_W-1:0] r_col_cnt;
    logic [ROW_W-1:0] r_row_cnt;
    logic [COL_W-1:0] n_col_cnt;
    logic [ROW_W-1:0] n_row_cnt;

    logic             w_en;
    logic             w_accept;
    logic [COL_W-1:0] w_c;
    logic [ROW_W-1:0] w_r;
    logic [WID_W-1:0] w_width_eff;
    logic [HGT_W-1:0] w_height_eff;
    logic [WID_W-1:0] w_c_inc;
    logic [HGT_W-1:0] w_r_inc;

    logic             r_s2_valid;
    t_pix             r_s2_px;
    logic [COL_W-1:0] r_s2_c;
    logic [ROW_W-1:0] r_s2_r;

    logic             r_s3_valid;
    logic [COL_W-1:0] r_s3_col;
    logic [ROW_W-1:0] r_s3_row;
    logic             r_s4_valid;
    logic [COL_W-1:0] r_s4_col;
    logic [ROW_W-1:0] r_s4_row;

    logic             r_out_valid;
    t_out_req         r_out;
    t_out_req         n_out;

    t_pix  w_top;
    t_pix  w_mid;
    t_col  w_col [0:3];
    t_psum w_psum [0:2];
    logic signed [SUM_W-1:0] w_sum_red;
    logic signed [SUM_W-1:0] w_sum_green;
    logic signed [SUM_W-1:0] w_sum_blue;

    // advance the pipeline unless a result is held by the consumer
    assign w_en        = !r_out_valid || !i_out_stall;
    assign w_accept    = i_in_valid && w_en;
    assign o_in_stall  = !w_en;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_req   = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kernel <= KERNEL_RST;
            r_shift  <= SHIFT_RST;
            r_width  <= WIDTH_RST;
            r_height <= HEIGHT_RST;
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_KERNEL: r_kernel <= i_cfg_data;
                CFG_SHIFT:  r_shift  <= i_cfg_data[SHIFT_W-1:0];
                CFG_WIDTH:  r_width  <= i_cfg_data[WID_W-1:0];
                CFG_HEIGHT: r_height <= i_cfg_data[HGT_W-1:0];
                default:    r_kernel <= r_kernel;
            endcase
        end
    end

    // position of this pixel and of the next one
    always_comb begin
        w_c          = i_in_req.frame_start ? '0 : r_col_cnt;
        w_r          = i_in_req.frame_start ? '0 : r_row_cnt;
        w_width_eff  = (r_width > WID_W'(MAX_WIDTH)) ? WID_W'(MAX_WIDTH) : r_width;
        w_height_eff = (r_height > HGT_W'(MAX_HEIGHT)) ? HGT_W'(MAX_HEIGHT) : r_height;
        w_c_inc      = {1'b0, w_c} + WID_W'(1);
        w_r_inc      = {1'b0, w_r} + HGT_W'(1);
        n_col_cnt    = w_c_inc[COL_W-1:0];
        n_row_cnt    = w_r;
        if (w_c_inc >= w_width_eff) begin
            n_col_cnt = '0;
            n_row_cnt = (w_r_inc >= w_height_eff) ? '0 : w_r_inc[ROW_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col_cnt   <= '0;
            r_row_cnt   <= '0;
            r_s2_valid  <= 1'b0;
            r_s3_valid  <= 1'b0;
            r_s4_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            if (w_accept) begin
                r_col_cnt <= n_col_cnt;
                r_row_cnt <= n_row_cnt;
            end
            r_s2_valid  <= w_accept;
            r_s3_valid  <= r_s2_valid && (r_s2_c >= COL_W'(2)) && (r_s2_r >= ROW_W'(2));
            r_s4_valid  <= r_s3_valid;
            r_out_valid <= r_s4_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s2_px  <= '{red: i_in_req.red_in, green: i_in_req.green_in,
                          blue: i_in_req.blue_in};
            r_s2_c   <= w_c;
            r_s2_r   <= w_r;
            r_s3_col <= r_s2_c - COL_W'(1);
            r_s3_row <= r_s2_r - ROW_W'(1);
            r_s4_col <= r_s3_col;
            r_s4_row <= r_s3_row;
            r_out    <= n_out;
        end
    end

    rgb3_line_buf u_line_buf (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (w_en),
        .i_rd_addr (w_c),
        .i_wr_en   (r_s2_valid && w_en),
        .i_wr_addr (r_s2_c),
        .i_wr_px   (r_s2_px),
        .o_top     (w_top),
        .o_mid     (w_mid)
    );

    assign w_col[3] = '{top: w_top, mid: w_mid, bot: r_s2_px};

    // cell 2 takes the newest column, cell 0 the oldest
    rgb3_tap_cell u_cell2 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_shift (r_s2_valid && w_en),
        .i_en    (w_en),
        .i_col   (w_col[3]),
        .i_coefs (r_kernel[35:24]),
        .o_col   (w_col[2]),
        .o_psum  (w_psum[2])
    );

    rgb3_tap_cell u_cell1 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_shift (r_s2_valid && w_en),
        .i_en    (w_en),
        .i_col   (w_col[2]),
        .i_coefs (r_kernel[23:12]),
        .o_col   (w_col[1]),
        .o_psum  (w_psum[1])
    );

    rgb3_tap_cell u_cell0 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_shift (r_s2_valid && w_en),
        .i_en    (w_en),
        .i_col   (w_col[1]),
        .i_coefs (r_kernel[11:0]),
        .o_col   (w_col[0]),
        .o_psum  (w_psum[0])
    );

    always_comb begin
        w_sum_red   = SUM_W'(w_psum[0].red)   + SUM_W'(w_psum[1].red)
                    + SUM_W'(w_psum[2].red);
        w_sum_green = SUM_W'(w_psum[0].green) + SUM_W'(w_psum[1].green)
                    + SUM_W'(w_psum[2].green);
        w_sum_blue  = SUM_W'(w_psum[0].blue)  + SUM_W'(w_psum[1].blue)
                    + SUM_W'(w_psum[2].blue);
        n_out.red_out       = norm_ch(w_sum_red,   r_shift);
        n_out.green_out     = norm_ch(w_sum_green, r_shift);
        n_out.blue_out      = norm_ch(w_sum_blue,  r_shift);
        n_out.centre_column = r_s4_col;
        n_out.centre_row    = r_s4_row;
    end

endmodule

`default_nettype wire

>>> rtl/core/rgb3_chk.sv
// Port-level checker for the RGB 3x3 convolution filter, bound to the top level.
`default_nettype none

module rgb3_chk
    import rgb3_pkg::*;
(
    input wire logic                 i_clk,
    input wire logic                 i_rst_n,
    input wire logic                 o_in_stall,
    input wire logic                 o_out_valid,
    input wire logic                 i_out_stall,
    input wire t_out_req             o_out_req
);

    // a held result keeps its value until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_req)))
        else $error("result changed while stalled");

    // input backs up only behind a stalled result
    a_in_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (o_out_valid && i_out_stall))
        else $error("input stalled without a held result");

    // first-row and first-column pixels never appear as centres
    a_interior: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_out_req.centre_column != '0) && (o_out_req.centre_row != '0)))
        else $error("result at a border position");

    // reset empties the output
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result present after reset");

endmodule

bind rgb_3x3_convolution_filter rgb3_chk u_rgb3_chk (.*);

`default_nettype wire
